FILE: rtl/text_glyph_row_renderer_macros.svh
// Assertion macros shared by the checker of the text glyph row renderer.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef TEXT_GLYPH_ROW_RENDERER_MACROS_SVH
`define TEXT_GLYPH_ROW_RENDERER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgr assertion failed");

`endif

FILE: rtl/tgr_pkg.sv
// Shared types and constants of the text glyph row renderer.
// No dependencies; imported by every module of the block.
package tgr_pkg;

    localparam int FONT_STORE_BYTES = 8192;
    localparam int FONT_AW          = $clog2(FONT_STORE_BYTES);
    localparam int GLYPH_ROWS       = 16;
    localparam int ROW_W            = $clog2(GLYPH_ROWS);
    localparam int GLYPH_COLUMNS    = 8;

    localparam int CHAR_W    = 8;
    localparam int STRIDE_W  = 6;
    localparam int GBASE_W   = CHAR_W + STRIDE_W;
    localparam int RSUM_W    = ((GBASE_W > FONT_AW) ? GBASE_W : FONT_AW) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic CMD_FONT_WRITE = 1'b0;
    localparam logic CMD_PUT_CHAR   = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_BASE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRAW_COLOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_STRIDE = 3'd4;

    typedef struct packed {
        logic                command;
        logic [FONT_AW-1:0]  font_address;
        logic [7:0]          font_byte;
        logic [CHAR_W-1:0]   character;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [7:0]  row_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } t_out_item;

    typedef struct packed {
        logic [15:0]         screen_width;
        logic [15:0]         line_pitch;
        logic [31:0]         frame_base;
        logic [31:0]         draw_color;
        logic [STRIDE_W-1:0] glyph_stride;
    } t_cfg;

    typedef struct packed {
        logic                command;
        logic [FONT_AW-1:0]  font_address;
        logic [7:0]          font_byte;
        logic [CHAR_W-1:0]   character;
        logic [15:0]         cursor_x;
        logic [15:0]         cursor_y;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: rtl/tgr_front.sv
// Front end: accepts items, keeps the text cursor and queues jobs.
// Depends on tgr_pkg.
module tgr_front
    import tgr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_item      i_in_item,
    input  logic [15:0]   i_screen_width,
    input  t_queue_status i_queue,
    output logic          o_push,
    output t_job          o_job
);

    logic [15:0] r_cursor_x;
    logic [15:0] r_cursor_y;
    logic [15:0] n_cursor_x;
    logic [15:0] n_cursor_y;
    logic        accept;
    logic        is_char;
    logic        is_newline;
    logic        wrap;

    always_comb begin
        o_in_stall = i_queue.full;
        accept     = i_in_valid && !i_queue.full;
        is_char    = (i_in_item.command == CMD_PUT_CHAR);
        is_newline = (i_in_item.character == NEWLINE_CODE);
        wrap       = (r_cursor_x > i_screen_width) || is_newline;
        // advance before draw: the glyph lands at the moved cursor
        if (wrap) begin
            n_cursor_x = '0;
            n_cursor_y = r_cursor_y + 16'(GLYPH_ROWS);
        end else begin
            n_cursor_x = r_cursor_x + 16'(GLYPH_COLUMNS);
            n_cursor_y = r_cursor_y;
        end
        o_push = accept && (!is_char || !is_newline);
        o_job  = '{command:      i_in_item.command,
                   font_address: i_in_item.font_address,
                   font_byte:    i_in_item.font_byte,
                   character:    i_in_item.character,
                   cursor_x:     n_cursor_x,
                   cursor_y:     n_cursor_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else if (accept && is_char) begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end

endmodule

FILE: rtl/tgr_queue.sv
// Short job queue between front end and render engine.
// Depends on tgr_pkg.
module tgr_queue
    import tgr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_job,
    output t_queue_status o_status
);

    t_job                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    always_comb begin
        o_job          = r_entry[r_rd_ptr];
        o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/tgr_back.sv
// Render engine: glyph store, row sequencer and output registers.
// Depends on tgr_pkg.
module tgr_back
    import tgr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_job          i_job,
    input  t_queue_status i_queue,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out_item     o_out_item
);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_ROWS} t_state;

    t_state             r_state;
    logic [7:0]         r_glyph_mem [FONT_STORE_BYTES];
    logic [7:0]         r_rd_data;
    logic [GBASE_W-1:0] r_gbase;
    logic [31:0]        r_prod;
    logic [15:0]        r_x;
    logic [31:0]        r_row_addr;
    logic [ROW_W-1:0]   r_row;
    logic               r_a_valid;
    logic [31:0]        r_a_addr;
    logic [31:0]        r_a_color;
    logic               r_a_last;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               b_free;
    logic               a_move;
    logic               a_free;
    logic               issue;
    logic               wr_en;
    logic               row_last;
    logic [RSUM_W-1:0]  rd_sum;
    logic [FONT_AW-1:0] rd_addr;

    always_comb begin
        b_free   = !r_out_valid || !i_out_stall;
        a_move   = r_a_valid && b_free;
        a_free   = !r_a_valid || a_move;
        issue    = (r_state == S_ROWS) && a_free;
        o_pop    = (r_state == S_IDLE) && !i_queue.empty;
        wr_en    = o_pop && (i_job.command == CMD_FONT_WRITE);
        row_last = (r_row == ROW_W'(GLYPH_ROWS - 1));
        rd_sum   = RSUM_W'(r_gbase) + RSUM_W'(r_row);
        rd_addr  = rd_sum[FONT_AW-1:0];
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_glyph_mem[i_job.font_address] <= i_job.font_byte;
        end
        if (issue) begin
            r_rd_data <= r_glyph_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_job.command == CMD_PUT_CHAR)) begin
                        r_gbase <= GBASE_W'(i_job.character) * GBASE_W'(i_cfg.glyph_stride);
                        r_prod  <= 32'(i_job.cursor_y) * 32'(i_cfg.line_pitch);
                        r_x     <= i_job.cursor_x;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_row_addr <= i_cfg.frame_base + 32'(r_x) + r_prod;
                    r_row      <= '0;
                    r_state    <= S_ROWS;
                end
                S_ROWS: begin
                    if (issue) begin
                        r_row_addr <= r_row_addr + 32'(i_cfg.line_pitch);
                        r_row      <= r_row + ROW_W'(1);
                        if (row_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (issue) begin
                r_a_valid <= 1'b1;
                r_a_addr  <= r_row_addr;
                r_a_color <= i_cfg.draw_color;
                r_a_last  <= row_last;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end

            if (a_move) begin
                r_out_valid <= 1'b1;
                r_out_item  <= '{pixel_address: r_a_addr,
                                 row_mask:      r_rd_data,
                                 pixel_color:   r_a_color,
                                 last_row:      r_a_last};
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/text_glyph_row_renderer.sv
// Text glyph row renderer top level: APB registers, front end, job queue, render engine.
// Each drawn character takes a pop, an address sum and one glyph-store read per row; the engine
// takes no new job until its last row is issued, and rows wait while the result channel stalls.
// A font write occupies the engine only for its pop; a newline never reaches the engine.
// Reset: synchronous active-low; clears cursor, queue, sequencer and registers to defaults.
// The glyph store is not cleared: it is undefined until written. Depends on tgr_pkg.
module text_glyph_row_renderer
    import tgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    // row result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]         r_screen_width;
    logic [15:0]         r_line_pitch;
    logic [31:0]         r_frame_base;
    logic [31:0]         r_draw_color;
    logic [STRIDE_W-1:0] r_glyph_stride;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    t_cfg                 cfg;
    logic                 push;
    logic                 pop;
    t_job                 push_job;
    t_job                 pop_job;
    t_queue_status        queue_status;

    // Register file: word-aligned, low address bits ignored, unmapped reads return zero.
    always_comb begin
        reg_idx   = paddr[APB_AW-1:2];
        cfg_write = psel && penable && pwrite;
        pready    = 1'b1;
        case (reg_idx)
            REG_SCREEN_WIDTH: prdata = 32'(r_screen_width);
            REG_LINE_PITCH:   prdata = 32'(r_line_pitch);
            REG_FRAME_BASE:   prdata = r_frame_base;
            REG_DRAW_COLOR:   prdata = r_draw_color;
            REG_GLYPH_STRIDE: prdata = 32'(r_glyph_stride);
            default:          prdata = '0;
        endcase
        cfg = '{screen_width: r_screen_width,
                line_pitch:   r_line_pitch,
                frame_base:   r_frame_base,
                draw_color:   r_draw_color,
                glyph_stride: r_glyph_stride};
    end

    // Keep only the low bits of each register; drop writes beyond the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= 16'd640;
            r_line_pitch   <= 16'd640;
            r_frame_base   <= '0;
            r_draw_color   <= '1;
            r_glyph_stride <= STRIDE_W'(16);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SCREEN_WIDTH: r_screen_width <= pwdata[15:0];
                REG_LINE_PITCH:   r_line_pitch   <= pwdata[15:0];
                REG_FRAME_BASE:   r_frame_base   <= pwdata;
                REG_DRAW_COLOR:   r_draw_color   <= pwdata;
                REG_GLYPH_STRIDE: r_glyph_stride <= pwdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: classify, advance the cursor, queue font writes and glyph jobs.
    tgr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_screen_width (r_screen_width),
        .i_queue        (queue_status),
        .o_push         (push),
        .o_job          (push_job)
    );

    // Decouple the two sides so input transfers continue while rows drain.
    tgr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (queue_status)
    );

    // Back end: write glyph store in order, read and emit one row per cycle unless stalled.
    tgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (pop_job),
        .i_queue     (queue_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/tgr_checker.sv
// Port-level checker for the text glyph row renderer, bound to the top level.
// Depends on tgr_pkg and text_glyph_row_renderer_macros.svh.
`include "text_glyph_row_renderer_macros.svh"

module tgr_checker
    import tgr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_item          i_in_item,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_item,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    logic [ROW_W-1:0] r_rows;
    logic [7:0]       r_pending;
    logic [15:0]      r_pitch;
    logic [31:0]      r_prev_addr;
    logic             out_xfer;
    logic             glyph_in;
    logic             pitch_wr;
    logic             unused_ok;

    always_comb begin
        out_xfer  = o_out_valid && !i_out_stall;
        glyph_in  = i_in_valid && !o_in_stall && (i_in_item.command == CMD_PUT_CHAR)
                    && (i_in_item.character != NEWLINE_CODE);
        pitch_wr  = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1:2] == REG_LINE_PITCH);
        unused_ok = |prdata || 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= '0;
            r_pending <= '0;
            r_pitch   <= 16'd640;
        end else begin
            if (out_xfer) begin
                r_rows      <= r_rows + ROW_W'(1);
                r_prev_addr <= o_out_item.pixel_address;
            end
            if (glyph_in && !(out_xfer && o_out_item.last_row)) begin
                r_pending <= r_pending + 8'd1;
            end else if (!glyph_in && out_xfer && o_out_item.last_row) begin
                r_pending <= r_pending - 8'd1;
            end
            if (pitch_wr) begin
                r_pitch <= pwdata[15:0];
            end
        end
    end

    // a stalled row result holds
    `TGR_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    // last_row marks exactly the final row of each glyph
    `TGR_ASSERT_IMP(a_last_row, out_xfer && unused_ok, o_out_item.last_row == (r_rows == ROW_W'(GLYPH_ROWS - 1)))
    // consecutive rows of one glyph step by the line pitch
    `TGR_ASSERT_IMP(a_row_step, out_xfer && (r_rows != '0), o_out_item.pixel_address == r_prev_addr + 32'(r_pitch))
    // no row result without a drawn character outstanding
    `TGR_ASSERT_IMP(a_no_orphan, out_xfer, r_pending != '0)

endmodule

bind text_glyph_row_renderer tgr_checker u_tgr_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for text_glyph_row_renderer: drives font loads and characters,
// predicts every glyph row it must return, and checks the APB register file.
// Depends on tgr_pkg and the text_glyph_row_renderer RTL only.
module tb_top;
    import tgr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // The job queue holds 4 entries; the drain covers a full queue and the tail of the engine.
    localparam int DRAIN_CYCLES  = 40;
    // Item count that ends random traffic, counted over the whole run, glyph loads included.
    localparam int RANDOM_ITEMS  = 460;
    localparam int RANDOM_PHASES = 6;
    localparam int POOL_SIZE     = 4;
    localparam int MAX_REPORTS   = 40;
    // Index past the register list; writes here must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Clock, reset and all block inputs start at known values.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_item   = '0;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    t_out_item         o_out_item;
    logic [31:0]       prdata;
    logic              pready;

    text_glyph_row_renderer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers, cursor and glyph store
    // ------------------------------------------------------------------
    logic [15:0]         cfg_width;
    logic [15:0]         cfg_pitch;
    logic [31:0]         cfg_base;
    logic [31:0]         cfg_color;
    logic [STRIDE_W-1:0] cfg_stride;
    logic [15:0]         cursor_x;
    logic [15:0]         cursor_y;
    logic [7:0]          glyph_bytes [FONT_STORE_BYTES];
    // Tracks which store bytes hold data; glyphs are only drawn once all rows are loaded.
    bit                  glyph_loaded [FONT_STORE_BYTES];

    t_out_item pending_rows [$];
    t_out_item expected_row;

    int  error_count = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    bit  steady      = 1'b0;   // no gaps and no stalls while set
    int  stall_left  = 0;
    int  stall_roll  = 0;
    logic [7:0] char_pool [POOL_SIZE];

    // Print one line per mismatch, up to a cap, and count them all.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("[%0d] mismatch on %s: got %h, want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Apply one accepted transfer to the predictor and queue the rows it draws.
    // The cursor moves first; the glyph lands at the advanced position.
    function automatic void predict_rows(input t_in_item it);
        logic [31:0] line_no;
        logic [31:0] glyph_at;
        t_out_item   row;
        if (it.command == CMD_FONT_WRITE) begin
            glyph_bytes[it.font_address]  = it.font_byte;
            glyph_loaded[it.font_address] = 1'b1;
            return;
        end
        if (cursor_x > cfg_width || it.character == NEWLINE_CODE) begin
            cursor_x = '0;
            cursor_y = 16'(cursor_y + GLYPH_ROWS);
        end else begin
            cursor_x = 16'(cursor_x + GLYPH_COLUMNS);
        end
        if (it.character == NEWLINE_CODE)
            return;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            // Row line is formed at 32 bits; the address wraps modulo 2^32.
            line_no  = 32'(cursor_y) + 32'(r);
            glyph_at = 32'(it.character) * 32'(cfg_stride) + 32'(r);
            row.pixel_address = cfg_base + 32'(cursor_x) + line_no * 32'(cfg_pitch);
            row.row_mask      = glyph_bytes[glyph_at[FONT_AW-1:0]];
            row.pixel_color   = cfg_color;
            row.last_row      = (r == GLYPH_ROWS - 1);
            pending_rows.push_back(row);
        end
    endfunction

    function automatic logic [31:0] register_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_SCREEN_WIDTH: return 32'(cfg_width);
            REG_LINE_PITCH:   return 32'(cfg_pitch);
            REG_FRAME_BASE:   return cfg_base;
            REG_DRAW_COLOR:   return cfg_color;
            REG_GLYPH_STRIDE: return 32'(cfg_stride);
            default:          return '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, mostly short bursts with a few long holds
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || steady) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 20)
                stall_left = $urandom_range(1, 3);
            else if (stall_roll < 23)
                stall_left = $urandom_range(10, 40);
            else
                stall_left = 0;
        end
    end

    // Check every row transfer against the oldest expected row.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected row", o_out_item.pixel_address, '0);
            end else begin
                expected_row = pending_rows.pop_front();
                if (o_out_item.pixel_address !== expected_row.pixel_address)
                    report_mismatch("pixel_address", o_out_item.pixel_address,
                                    expected_row.pixel_address);
                if (o_out_item.row_mask !== expected_row.row_mask)
                    report_mismatch("row_mask", 32'(o_out_item.row_mask),
                                    32'(expected_row.row_mask));
                if (o_out_item.pixel_color !== expected_row.pixel_color)
                    report_mismatch("pixel_color", o_out_item.pixel_color,
                                    expected_row.pixel_color);
                if (o_out_item.last_row !== expected_row.last_row)
                    report_mismatch("last_row", 32'(o_out_item.last_row),
                                    32'(expected_row.last_row));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows outstanding",
                     cycle_count, pending_rows.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------
    // Send one item and wait for its transfer. Valid stays high on return so a
    // back-to-back item follows without a bubble; any caller that lets time pass
    // otherwise must go through settle() first.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_rows(it);
        items_sent++;
    endtask

    task automatic send_font(input logic [FONT_AW-1:0] addr, input logic [7:0] value);
        t_in_item it;
        it.command      = CMD_FONT_WRITE;
        it.font_address = addr;
        it.font_byte    = value;
        it.character    = 8'($urandom);
        send_item(it);
    endtask

    // Put one character; load any glyph row it would read that holds no data yet.
    task automatic send_char(input logic [7:0] ch);
        t_in_item    it;
        logic [31:0] glyph_at;
        if (ch != NEWLINE_CODE) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                glyph_at = 32'(ch) * 32'(cfg_stride) + 32'(r);
                if (!glyph_loaded[glyph_at[FONT_AW-1:0]])
                    send_font(glyph_at[FONT_AW-1:0], 8'($urandom));
            end
        end
        it.command      = CMD_PUT_CHAR;
        it.font_address = FONT_AW'($urandom);
        it.font_byte    = 8'($urandom);
        it.character    = ch;
        send_item(it);
    endtask

    // Drop valid, wait for every expected row, then let queued font writes
    // retire inside the engine.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== register_value(idx))
            report_mismatch($sformatf("register %0d readback", idx), rdata,
                            register_value(idx));
    endtask

    // Write a register while the block is idle; only the register's low bits stick.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] rdata;
        settle();
        apb_access(1'b1, idx, value, rdata);
        case (idx)
            REG_SCREEN_WIDTH: cfg_width  = value[15:0];
            REG_LINE_PITCH:   cfg_pitch  = value[15:0];
            REG_FRAME_BASE:   cfg_base   = value;
            REG_DRAW_COLOR:   cfg_color  = value;
            REG_GLYPH_STRIDE: cfg_stride = value[STRIDE_W-1:0];
            default: ;
        endcase
        if (idx != REG_UNUSED)
            check_register(idx);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        check_register(REG_SCREEN_WIDTH);
        check_register(REG_LINE_PITCH);
        check_register(REG_FRAME_BASE);
        check_register(REG_DRAW_COLOR);
        check_register(REG_GLYPH_STRIDE);
    endtask

    // Load glyph 0 with edge patterns and draw it twice in a row.
    task automatic test_glyph_load_and_draw();
        logic [7:0] pattern [GLYPH_ROWS];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F, 8'hFE,
                    8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hC3, 8'h3C};
        for (int r = 0; r < GLYPH_ROWS; r++)
            send_font(FONT_AW'(r), pattern[r]);
        // Top of the store, all bits set.
        send_font({FONT_AW{1'b1}}, 8'hFF);
        send_char(8'd0);
        send_char(8'd0);
    endtask

    // The wrap when cursor_x passes a narrow screen, then a newline.
    task automatic test_newline_and_line_wrap();
        cfg_write(REG_SCREEN_WIDTH, 32'd8);
        send_char(8'd0);
        send_char(8'd0);
        send_char(8'd0);
        send_char(NEWLINE_CODE);
        send_char(8'd0);
    endtask

    task automatic test_degenerate_settings();
        // Zero stride: every character reads glyph 0. Zero pitch: all rows share an address.
        cfg_write(REG_GLYPH_STRIDE, 32'd0);
        cfg_write(REG_LINE_PITCH, 32'd0);
        send_char(8'hFF);
        // Address wraps past 2^32; width zero wraps on every other character.
        cfg_write(REG_LINE_PITCH, 32'hDEAD_FFFF);
        cfg_write(REG_FRAME_BASE, 32'hFFFF_FF00);
        cfg_write(REG_SCREEN_WIDTH, 32'hBEEF_0000);
        send_char(8'd1);
        send_char(8'd2);
        cfg_write(REG_SCREEN_WIDTH, 32'h0000_FFFF);
        cfg_write(REG_DRAW_COLOR, 32'h0000_0000);
        // Out-of-range register index: nothing may change.
        cfg_write(REG_UNUSED, 32'h1234_5678);
        send_char(8'h80);
        settle();
        test_register_defaults_after_unused();
    endtask

    // Every real register must still read its last written value.
    task automatic test_register_defaults_after_unused();
        test_register_defaults();
    endtask

    // Phases of random traffic, each under its own register setting.
    task automatic test_random_traffic();
        int phase_end;
        int roll;
        logic [7:0] ch;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cfg_write(REG_SCREEN_WIDTH, phase == 1 ? 32'h0000_FFFF :
                                        phase == 2 ? 32'h0000_0000 :
                                        {16'($urandom), 16'($urandom_range(0, 400))});
            cfg_write(REG_LINE_PITCH,   phase == 3 ? 32'h0000_FFFF :
                                        phase == 4 ? 32'd1 :
                                        phase == 5 ? 32'd0 : $urandom);
            cfg_write(REG_FRAME_BASE,   phase == 0 ? 32'd0 :
                                        phase == 1 ? 32'hFFFF_FFFF : $urandom);
            cfg_write(REG_DRAW_COLOR,   phase == 2 ? 32'd0 :
                                        phase == 3 ? 32'hFFFF_FFFF : $urandom);
            cfg_write(REG_GLYPH_STRIDE, phase == 0 ? 32'd63 :
                                        phase == 1 ? 32'd1 :
                                        phase == 2 ? 32'd32 : $urandom);
            // Keep most text within a small character set so glyphs get reused.
            foreach (char_pool[k])
                char_pool[k] = 8'($urandom);
            steady = (phase == 4);
            // Count every item sent, glyph loads included.
            phase_end = (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    // Stray font write anywhere in the store.
                    send_font(FONT_AW'($urandom), 8'($urandom));
                end else if (roll < 22) begin
                    send_char(NEWLINE_CODE);
                end else if (roll < 25) begin
                    // Hold off until the block has delivered everything.
                    settle();
                end else begin
                    ch = ($urandom_range(0, 99) < 85) ? char_pool[$urandom_range(0, POOL_SIZE-1)]
                                                      : 8'($urandom);
                    send_char(ch);
                end
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_width  = 16'd640;
        cfg_pitch  = 16'd640;
        cfg_base   = 32'd0;
        cfg_color  = 32'hFFFF_FFFF;
        cfg_stride = STRIDE_W'(16);
        cursor_x   = '0;
        cursor_y   = '0;
        foreach (glyph_bytes[k]) begin
            glyph_bytes[k]  = '0;
            glyph_loaded[k] = 1'b0;
        end

        // Hold reset, then release it away from the sampling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_glyph_load_and_draw();
        test_newline_and_line_wrap();
        test_degenerate_settings();
        test_random_traffic();

        // Drain: every expected row in, then the tail of the engine.
        settle();
        if (error_count == 0 && pending_rows.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
